/* rtl/tcf_pkg.sv */
// shared types and constants of the tcp connection table
`timescale 1ns / 1ps
package tcf_pkg;
	localparam int TableEntries = 16;

	localparam logic [7:0] TCP_FIN = 8'h01;
	localparam logic [7:0] TCP_SYN = 8'h02;
	localparam logic [7:0] TCP_RST = 8'h04;
	localparam logic [7:0] TCP_ACK = 8'h10;
	localparam logic [7:0] FLAGS_RST_ACK = TCP_RST | TCP_ACK;
	localparam logic [7:0] FLAGS_FIN_ACK = TCP_FIN | TCP_ACK;

	localparam logic [1:0] MODE_SEG = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_CLOSE = 2'd2;
	localparam logic [1:0] MODE_TAKE = 2'd3;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_SEND = 2'd1;
	localparam logic [1:0] ACT_LISTEN = 2'd2;
	localparam logic [1:0] ACT_HAND = 2'd3;

	localparam logic [3:0] ST_CLOSED = 4'd0;
	localparam logic [3:0] ST_LISTEN = 4'd1;
	localparam logic [3:0] ST_SYNSENT = 4'd2;
	localparam logic [3:0] ST_SYNRCVD = 4'd3;
	localparam logic [3:0] ST_ESTAB = 4'd4;
	localparam logic [3:0] ST_FINWAIT1 = 4'd5;
	localparam logic [3:0] ST_FINWAIT2 = 4'd6;
	localparam logic [3:0] ST_CLOSEWAIT = 4'd7;
	localparam logic [3:0] ST_LASTACK = 4'd8;
	localparam logic [3:0] ST_TIMEWAIT = 4'd9;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] slot;
		logic [31:0] peer_addr;
		logic [15:0] peer_port_in;
		logic [15:0] own_port;
		logic [31:0] seq_in;
		logic [31:0] ack_in;
		logic [7:0] tcp_flags;
		logic [15:0] payload_bytes;
		logic segment_ok;
		logic [3:0] write_state;
		logic write_valid;
	} req_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] out_flags;
		logic [31:0] out_seq;
		logic [31:0] out_ack;
		logic [31:0] dest_addr;
		logic [15:0] dest_port;
		logic [15:0] src_port_out;
		logic [3:0] slot_out;
		logic [3:0] new_state;
		logic [15:0] payload_accepted;
		logic last;
	} rsp_t;

	// one table row, kept in a single memory word
	typedef struct packed {
		logic active;
		logic [3:0] state;
		logic [15:0] lport;
		logic [31:0] rip;
		logic [15:0] rport;
		logic [31:0] snd_nxt;
		logic [31:0] snd_una;
		logic [31:0] rcv_nxt;
		logic pend;
		logic [31:0] pip;
		logic [15:0] pport;
		logic [31:0] pseq;
	} row_t;
endpackage

/* rtl/tcf_if.sv */
// valid/ready channel carrying one payload word
`timescale 1ns / 1ps
interface tcf_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/tcf_ram.sv */
// generic ram with one write port and one registered read port
`timescale 1ns / 1ps
module tcf_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/tcp_connection_table_fsm.sv */
// tcp connection table top level: scan and update sequencer over a row memory
//
// Channels: req (sink) takes one command item per transfer; rsp (source)
// gives up to two result items per command, the final one marked by last.
// A segment walks the whole table once, one row read per cycle from the row
// memory: a matched segment then rereads its row (S_RD) before the execute
// step (S_EXEC) registers its first result; an unmatched one goes from the
// scan straight to S_EXEC. An unmatched SYN scans the table a second time
// for a listener. Slot commands read their row (S_RD), then S_EXEC registers
// the result. A segment with segment_ok low is taken and dropped without a
// result. Commands are handled one at a time; the next is taken once every
// result of the current one has been transferred. The single memory read
// port sets the rate. After reset a clearing pass writes every row once
// before the first command is taken. A stall on rsp holds the result register
// and the sequencer; nothing is dropped.
`timescale 1ns / 1ps
module tcp_connection_table_fsm
	import tcf_pkg::*;
#(
	parameter int TABLE_ENTRIES = TableEntries
) (
	input logic clk,
	input logic arst_n,
	tcf_if.sink req,
	tcf_if.source rsp
);
	localparam int AW = $clog2(TABLE_ENTRIES > 1 ? TABLE_ENTRIES : 2);
	localparam int RW = $bits(row_t);

	localparam logic [2:0] S_CLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_LST = 3'd3;
	localparam logic [2:0] S_RD = 3'd4;
	localparam logic [2:0] S_EXEC = 3'd5;
	localparam logic [2:0] S_OUT = 3'd6;

	logic [2:0] st_q;
	req_t r_q;
	logic [AW:0] cnt_q;
	logic rvalid_q;
	logic [AW-1:0] ridx_q;
	logic hit_q;
	logic [AW-1:0] hidx_q;
	logic [AW-1:0] tgt_q;
	rsp_t o0_q, o1_q;
	logic [1:0] nout_q;
	logic sel_q;
	logic ovalid_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	row_t wrow, rrow;
	logic [RW-1:0] rdata;

	tcf_ram #(.Width(RW), .Depth(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wrow),
		.raddr(raddr), .rdata(rdata)
	);
	assign rrow = row_t'(rdata);

	assign req.ready = (st_q == S_IDLE);
	assign rsp.valid = ovalid_q;
	assign rsp.data = sel_q ? o1_q : o0_q;

	logic match_c, lmatch_c;
	assign match_c = rrow.active && rrow.lport == r_q.own_port &&
		rrow.rip == r_q.peer_addr && rrow.rport == r_q.peer_port_in &&
		rrow.state != ST_LISTEN;
	assign lmatch_c = rrow.active && rrow.lport == r_q.own_port &&
		rrow.state == ST_LISTEN;

	// execute step: next row value and results
	row_t nrow;
	rsp_t e0, e1;
	logic [1:0] en;
	logic ewe;
	logic [31:0] sum_len;

	function automatic rsp_t ack_of(row_t w, logic [AW-1:0] i, logic [7:0] f,
			logic [15:0] acc);
		rsp_t o;
		o.action = ACT_SEND;
		o.out_flags = f;
		o.out_seq = w.snd_nxt;
		o.out_ack = w.rcv_nxt;
		o.dest_addr = w.rip;
		o.dest_port = w.rport;
		o.src_port_out = w.lport;
		o.slot_out = 4'(i);
		o.new_state = w.state;
		o.payload_accepted = acc;
		o.last = 1'b0;
		return o;
	endfunction

	always_comb begin
		logic [7:0] fl;
		fl = r_q.tcp_flags;
		nrow = rrow;
		e0 = '0;
		e1 = '0;
		en = 2'd0;
		ewe = 1'b0;
		sum_len = r_q.seq_in + 32'(r_q.payload_bytes);
		case (r_q.mode)
			MODE_WRITE: begin
				ewe = 1'b1;
				nrow.active = r_q.write_valid;
				nrow.state = (r_q.write_state > ST_TIMEWAIT) ? ST_CLOSED : r_q.write_state;
				nrow.rip = r_q.peer_addr;
				nrow.rport = r_q.peer_port_in;
				nrow.lport = r_q.own_port;
				nrow.snd_una = r_q.seq_in;
				nrow.snd_nxt = r_q.seq_in + 32'd1;
				nrow.rcv_nxt = r_q.ack_in;
				nrow.pend = 1'b0;
			end
			MODE_CLOSE: begin
				if (rrow.active) begin
					ewe = 1'b1;
					if (rrow.state == ST_ESTAB || rrow.state == ST_CLOSEWAIT) begin
						nrow.state = (rrow.state == ST_ESTAB) ? ST_FINWAIT1 : ST_LASTACK;
						e0 = ack_of(nrow, tgt_q, FLAGS_FIN_ACK, 16'd0);
						nrow.snd_nxt = rrow.snd_nxt + 32'd1;
						en = 2'd1;
					end else begin
						nrow.state = ST_CLOSED;
						nrow.active = 1'b0;
					end
				end
			end
			MODE_TAKE: begin
				if (rrow.active && rrow.state == ST_LISTEN && rrow.pend) begin
					ewe = 1'b1;
					nrow.pend = 1'b0;
					e0.action = ACT_HAND;
					e0.out_seq = rrow.pseq;
					e0.dest_addr = rrow.pip;
					e0.dest_port = rrow.pport;
					e0.src_port_out = rrow.lport;
					e0.slot_out = 4'(tgt_q);
					e0.new_state = ST_LISTEN;
					en = 2'd1;
				end
			end
			default: begin
				if (!hit_q) begin
					// listener found by the second scan
					if (rrow.active && rrow.lport == r_q.own_port &&
							rrow.state == ST_LISTEN && (fl & TCP_SYN) != 0 &&
							r_q.mode == MODE_SEG && cnt_q[0]) begin
						ewe = 1'b1;
						nrow.pend = 1'b1;
						nrow.pip = r_q.peer_addr;
						nrow.pport = r_q.peer_port_in;
						nrow.pseq = r_q.seq_in;
						e0.action = ACT_LISTEN;
						e0.out_seq = r_q.seq_in;
						e0.dest_addr = r_q.peer_addr;
						e0.dest_port = r_q.peer_port_in;
						e0.src_port_out = r_q.own_port;
						e0.slot_out = 4'(tgt_q);
						e0.new_state = ST_LISTEN;
						en = 2'd1;
					end else if ((fl & TCP_RST) == 0) begin
						e0.action = ACT_SEND;
						e0.out_flags = FLAGS_RST_ACK;
						e0.dest_addr = r_q.peer_addr;
						e0.dest_port = r_q.peer_port_in;
						e0.src_port_out = r_q.own_port;
						e0.new_state = ST_CLOSED;
						if ((fl & TCP_ACK) != 0) begin
							e0.out_seq = r_q.ack_in;
						end else begin
							e0.out_ack = sum_len + 32'((fl & TCP_SYN) != 0)
								+ 32'((fl & TCP_FIN) != 0);
						end
						en = 2'd1;
					end
				end else if ((fl & TCP_RST) != 0) begin
					ewe = 1'b1;
					nrow.state = ST_CLOSED;
					nrow.active = 1'b0;
				end else begin
					ewe = 1'b1;
					case (rrow.state)
						ST_SYNSENT: begin
							if ((fl & TCP_SYN) != 0 && (fl & TCP_ACK) != 0 &&
									r_q.ack_in == rrow.snd_nxt) begin
								nrow.rcv_nxt = r_q.seq_in + 32'd1;
								nrow.snd_una = r_q.ack_in;
								nrow.state = ST_ESTAB;
								e0 = ack_of(nrow, tgt_q, TCP_ACK, 16'd0);
								en = 2'd1;
							end
						end
						ST_SYNRCVD: begin
							if ((fl & TCP_ACK) != 0 && r_q.ack_in == rrow.snd_nxt) begin
								nrow.snd_una = r_q.ack_in;
								nrow.state = ST_ESTAB;
							end
						end
						ST_ESTAB: begin
							if ((fl & TCP_ACK) != 0) nrow.snd_una = r_q.ack_in;
							if (r_q.payload_bytes != 0 && r_q.seq_in == rrow.rcv_nxt) begin
								nrow.rcv_nxt = rrow.rcv_nxt + 32'(r_q.payload_bytes);
								if ((fl & TCP_FIN) != 0) nrow.state = ST_CLOSEWAIT;
								e0 = ack_of(nrow, tgt_q, TCP_ACK, r_q.payload_bytes);
								en = 2'd1;
							end
							if ((fl & TCP_FIN) != 0) begin
								nrow.rcv_nxt = sum_len + 32'd1;
								nrow.state = ST_CLOSEWAIT;
								if (en == 2'd1) begin
									e1 = ack_of(nrow, tgt_q, TCP_ACK, 16'd0);
									en = 2'd2;
								end else begin
									e0 = ack_of(nrow, tgt_q, TCP_ACK, 16'd0);
									en = 2'd1;
								end
							end
						end
						ST_FINWAIT1: begin
							if ((fl & TCP_ACK) != 0) begin
								nrow.snd_una = r_q.ack_in;
								if ((fl & TCP_FIN) == 0) nrow.state = ST_FINWAIT2;
							end
							if ((fl & TCP_FIN) != 0) begin
								nrow.rcv_nxt = r_q.seq_in + 32'd1;
								nrow.state = ST_TIMEWAIT;
								e0 = ack_of(nrow, tgt_q, TCP_ACK, 16'd0);
								en = 2'd1;
							end
						end
						ST_FINWAIT2: begin
							if ((fl & TCP_FIN) != 0) begin
								nrow.rcv_nxt = r_q.seq_in + 32'd1;
								nrow.state = ST_TIMEWAIT;
								e0 = ack_of(nrow, tgt_q, TCP_ACK, 16'd0);
								en = 2'd1;
							end
						end
						ST_LASTACK: begin
							if ((fl & TCP_ACK) != 0) begin
								nrow.state = ST_CLOSED;
								nrow.active = 1'b0;
							end
						end
						default: ;
					endcase
				end
			end
		endcase
		if (en == 2'd1) e0.last = 1'b1;
		if (en == 2'd2) e1.last = 1'b1;
	end

	// memory port control
	always_comb begin
		we = 1'b0;
		waddr = tgt_q;
		wrow = nrow;
		raddr = cnt_q[AW-1:0];
		case (st_q)
			S_CLR: begin
				we = 1'b1;
				waddr = cnt_q[AW-1:0];
				wrow = '0;
			end
			S_RD: raddr = tgt_q;
			S_EXEC: we = ewe;
			default: ;
		endcase
	end

	logic last_rd;
	assign last_rd = (cnt_q == (AW+1)'(TABLE_ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			r_q <= '0;
			cnt_q <= '0;
			rvalid_q <= 1'b0;
			ridx_q <= '0;
			hit_q <= 1'b0;
			hidx_q <= '0;
			tgt_q <= '0;
			o0_q <= '0;
			o1_q <= '0;
			ovalid_q <= 1'b0;
			sel_q <= 1'b0;
			nout_q <= '0;
		end else begin
			case (st_q)
				S_CLR: begin
					if (last_rd) begin
						st_q <= S_IDLE;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_IDLE: begin
					cnt_q <= '0;
					rvalid_q <= 1'b0;
					hit_q <= 1'b0;
					if (req.valid) begin
						r_q <= req.data;
						tgt_q <= AW'(req.data.slot);
						if (req.data.mode == MODE_SEG) begin
							st_q <= req.data.segment_ok ? S_SCAN : S_IDLE;
						end else if (32'(req.data.slot) < TABLE_ENTRIES) begin
							st_q <= S_RD;
						end
					end
				end
				S_SCAN, S_LST: begin
					// one row issued per cycle, compared in the next cycle
					if (!last_rd && cnt_q < (AW+1)'(TABLE_ENTRIES)) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						cnt_q <= (AW+1)'(TABLE_ENTRIES);
					end
					rvalid_q <= cnt_q < (AW+1)'(TABLE_ENTRIES);
					ridx_q <= cnt_q[AW-1:0];
					if (rvalid_q && !hit_q &&
							((st_q == S_SCAN) ? match_c : lmatch_c)) begin
						hit_q <= 1'b1;
						hidx_q <= ridx_q;
					end
					if (rvalid_q && ridx_q == AW'(TABLE_ENTRIES - 1)) begin
						rvalid_q <= 1'b0;
						cnt_q <= '0;
						if (hit_q || ((st_q == S_SCAN) ? match_c : lmatch_c)) begin
							tgt_q <= hit_q ? hidx_q : ridx_q;
							hit_q <= (st_q == S_SCAN);
							cnt_q <= {{AW{1'b0}}, (st_q == S_LST)};
							st_q <= S_RD;
						end else if (st_q == S_SCAN &&
								(r_q.tcp_flags & TCP_SYN) != 0) begin
							st_q <= S_LST;
						end else begin
							hit_q <= 1'b0;
							st_q <= S_EXEC;
						end
					end
				end
				S_RD: st_q <= S_EXEC;
				S_EXEC: begin
					o0_q <= e0;
					o1_q <= e1;
					nout_q <= en;
					sel_q <= 1'b0;
					if (en != 2'd0) begin
						ovalid_q <= 1'b1;
						st_q <= S_OUT;
					end else begin
						st_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (rsp.ready) begin
						if (nout_q == 2'd2 && !sel_q) begin
							sel_q <= 1'b1;
						end else begin
							ovalid_q <= 1'b0;
							sel_q <= 1'b0;
							st_q <= S_IDLE;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
